@@ hw/rtl/stsp_pkg.sv @@
// ----------------------------------------------------------------------------
// stsp_pkg
// Types and constants shared by the stripe request splitter modules.
// ----------------------------------------------------------------------------
package stsp_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned PageShift = 12;
  localparam int unsigned RowShift  = 34;

  localparam logic [CfgIdxW-1:0] CFG_BLOCK_PAGES  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEVICE_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_WIDTH    = 2'd2;

  localparam logic [30:0] MaxXfer = 31'd2147479552;

  typedef struct packed {
    logic [3:0]  dev;
    logic [47:0] doff;
    logic [47:0] addr;
    logic [30:0] len;
  } stsp_chunk_t;

  typedef struct packed {
    logic valid;
    logic err;
    logic dir;
  } stsp_job_t;

endpackage

@@ hw/rtl/stsp_ram.sv @@
// ----------------------------------------------------------------------------
// stsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/stsp_div.sv @@
// ----------------------------------------------------------------------------
// stsp_div
// Restoring divider, one quotient bit per cycle, 49-bit by 32-bit.
// ----------------------------------------------------------------------------
module stsp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [48:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [48:0] quot_o,
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [48:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, quot_q[48]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[47:0], ge};
      rem_d  = ge ? 32'(rem_sh - {1'b0, div_q}) : rem_sh[31:0];
      cnt_d  = cnt_q + 6'd1;
      if (cnt_q == 6'd48) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ hw/rtl/stsp_front.sv @@
// ----------------------------------------------------------------------------
// stsp_front
// Walks a request piece by piece, maps each piece to its device and writes
// the chunk descriptors into the chunk buffer.
// ----------------------------------------------------------------------------
module stsp_front #(
  parameter int unsigned MaxDevices = 16,
  parameter int unsigned MaxChunks  = 64,
  parameter int unsigned CntW       = $clog2(MaxChunks + 1),
  parameter int unsigned AddrW      = (MaxChunks > 1) ? $clog2(MaxChunks) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       func_i,
  input  logic [47:0]                request_offset_i,
  input  logic [35:0]                request_bytes_i,
  input  logic [47:0]                mem_address_i,
  input  logic [19:0]                block_pages_i,
  input  logic [4:0]                 device_count_i,
  input  logic [47:0]                row_width_i,
  output logic                       idle_o,
  output logic                       we_o,
  output logic [AddrW-1:0]           waddr_o,
  output stsp_pkg::stsp_chunk_t      wdata_o,
  output stsp_pkg::stsp_job_t        job_o,
  output logic [CntW-1:0]            job_cnt_o
);
  import stsp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_K1   = 9'b000000010,
    S_K2   = 9'b000000100,
    S_Q    = 9'b000001000,
    S_I    = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_DEV  = 9'b001000000,
    S_CHK  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [19:0]   pages;
  logic [4:0]    nd_raw, nd;
  logic [31:0]   bs;
  logic          dir_q, dir_d;
  logic [48:0]   off_q, off_d;
  logic [35:0]   rem_q, rem_d;
  logic [47:0]   addr_q, addr_d;
  logic [47:0]   doff_q, doff_d;
  logic [32:0]   left_q, left_d;
  logic [31:0]   rm_q, rm_d;
  logic [4:0]    k_q, k_d;
  logic [4:0]    i_q, i_d;
  logic [4:0]    dev_q, dev_d;
  logic [35:0]   q2_q, q2_d;
  logic [35:0]   prod_q, prod_d;
  logic [CntW-1:0] n_q, n_d;
  logic          err_q, err_d;
  logic [18:0]   rk;
  logic [19:0]   si;
  logic [32:0]   bsmr;
  logic [30:0]   t;
  logic [55:0]   prod_full;

  logic          div_start, div_done;
  logic [48:0]   div_a, div_quot;
  logic [31:0]   div_b, div_rem;

  assign pages  = (block_pages_i == '0) ? 20'd1 : block_pages_i;
  assign nd_raw = (device_count_i == '0) ? 5'd1 : device_count_i;
  assign nd     = (32'(nd_raw) > MaxDevices) ? 5'(MaxDevices) : nd_raw;
  assign bs     = 32'(pages) << PageShift;
  assign rk     = off_q[48:RowShift] * k_q[3:0];
  assign si     = {15'b0, i_q} + {1'b0, rk};
  assign bsmr   = {1'b0, bs} - {1'b0, rm_q};
  assign t      = (left_q > {2'b0, MaxXfer}) ? MaxXfer : left_q[30:0];
  assign prod_full = q2_q * pages;

  stsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    dir_d     = dir_q;
    off_d     = off_q;
    rem_d     = rem_q;
    addr_d    = addr_q;
    doff_d    = doff_q;
    left_d    = left_q;
    rm_d      = rm_q;
    k_d       = k_q;
    i_d       = i_q;
    dev_d     = dev_q;
    q2_d      = q2_q;
    prod_d    = prod_q;
    n_d       = n_q;
    err_d     = err_q;
    div_start = 1'b0;
    div_a     = off_q;
    div_b     = bs;
    we_o      = 1'b0;
    job_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i && (request_bytes_i != '0)) begin
          dir_d     = func_i;
          off_d     = {1'b0, request_offset_i};
          rem_d     = request_bytes_i;
          addr_d    = mem_address_i;
          n_d       = '0;
          err_d     = 1'b0;
          div_start = 1'b1;
          div_a     = {1'b0, row_width_i};
          state_d   = S_K1;
        end
      end
      S_K1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = div_quot;
          div_b     = {27'b0, nd};
          state_d   = S_K2;
        end
      end
      S_K2: begin
        if (div_done) begin
          k_d       = div_rem[4:0];
          div_start = 1'b1;
          state_d   = S_Q;
        end
      end
      S_Q: begin
        if (div_done) begin
          rm_d      = div_rem;
          div_start = 1'b1;
          div_a     = div_quot;
          div_b     = {27'b0, nd};
          state_d   = S_I;
        end
      end
      S_I: begin
        if (div_done) begin
          i_d     = div_rem[4:0];
          q2_d    = div_quot[35:0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d    = prod_full[35:0];
        div_start = 1'b1;
        div_a     = {29'b0, si};
        div_b     = {27'b0, nd};
        state_d   = S_DEV;
      end
      S_DEV: begin
        if (div_done) begin
          dev_d   = div_rem[4:0];
          doff_d  = {prod_q, 12'b0} + {16'b0, rm_q};
          left_d  = (rem_q < {3'b0, bsmr}) ? rem_q[32:0] : bsmr;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (n_q == CntW'(MaxChunks)) begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          we_o   = 1'b1;
          n_d    = n_q + 1'b1;
          addr_d = addr_q + {17'b0, t};
          doff_d = doff_q + {17'b0, t};
          left_d = left_q - {2'b0, t};
          rem_d  = rem_q - {5'b0, t};
          off_d  = off_q + {18'b0, t};
          if (left_q == {2'b0, t}) begin
            if (rem_q == {5'b0, t}) begin
              state_d = S_DONE;
            end else begin
              div_start = 1'b1;
              div_a     = off_d;
              state_d   = S_Q;
            end
          end
        end
      end
      S_DONE: begin
        job_o.valid = 1'b1;
        job_o.err   = err_q;
        job_o.dir   = dir_q;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q  <= dir_d;
    off_q  <= off_d;
    rem_q  <= rem_d;
    addr_q <= addr_d;
    doff_q <= doff_d;
    left_q <= left_d;
    rm_q   <= rm_d;
    k_q    <= k_d;
    i_q    <= i_d;
    dev_q  <= dev_d;
    q2_q   <= q2_d;
    prod_q <= prod_d;
  end

  assign idle_o       = (state_q == S_IDLE);
  assign waddr_o      = n_q[AddrW-1:0];
  assign wdata_o.dev  = dev_q[3:0];
  assign wdata_o.doff = doff_q;
  assign wdata_o.addr = addr_q;
  assign wdata_o.len  = t;
  assign job_cnt_o    = n_q;

endmodule

@@ hw/rtl/stsp_back.sv @@
// ----------------------------------------------------------------------------
// stsp_back
// Plays a finished job out of the chunk buffer, one descriptor per cycle,
// or sends the single error result.
// ----------------------------------------------------------------------------
module stsp_back #(
  parameter int unsigned MaxChunks = 64,
  parameter int unsigned CntW      = $clog2(MaxChunks + 1),
  parameter int unsigned AddrW     = (MaxChunks > 1) ? $clog2(MaxChunks) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stsp_pkg::stsp_job_t   job_i,
  input  logic [CntW-1:0]       job_cnt_i,
  output logic [AddrW-1:0]      raddr_o,
  input  stsp_pkg::stsp_chunk_t rdata_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output logic                  direction_o,
  output logic [3:0]            device_index_o,
  output logic [47:0]           device_offset_o,
  output logic [47:0]           chunk_address_o,
  output logic [30:0]           chunk_bytes_o,
  output logic                  last_o,
  output logic                  too_many_chunks_o
);
  import stsp_pkg::*;

  logic            run_q, run_d;
  logic            pend_q, pend_d;
  logic            lastp_q, lastp_d;
  logic            err_q, err_d;
  logic            dir_q, dir_d;
  logic [CntW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            at_end;

  assign at_end = (rd_q == cnt_q - 1'b1);

  always_comb begin
    run_d   = run_q;
    pend_d  = 1'b0;
    lastp_d = lastp_q;
    err_d   = 1'b0;
    dir_d   = dir_q;
    rd_d    = rd_q;
    cnt_d   = cnt_q;
    if (job_i.valid) begin
      dir_d = job_i.dir;
      if (job_i.err) begin
        err_d = 1'b1;
      end else begin
        run_d = 1'b1;
        rd_d  = '0;
        cnt_d = job_cnt_i;
      end
    end else if (run_q) begin
      pend_d  = 1'b1;
      lastp_d = at_end;
      rd_d    = rd_q + 1'b1;
      if (at_end) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      pend_q  <= 1'b0;
      lastp_q <= 1'b0;
      err_q   <= 1'b0;
      dir_q   <= 1'b0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      run_q   <= run_d;
      pend_q  <= pend_d;
      lastp_q <= lastp_d;
      err_q   <= err_d;
      dir_q   <= dir_d;
      rd_q    <= rd_d;
      cnt_q   <= cnt_d;
    end
  end

  assign raddr_o           = rd_q[AddrW-1:0];
  assign busy_o            = run_q | pend_q | err_q;
  assign valid_o           = pend_q | err_q;
  assign direction_o       = dir_q;
  assign device_index_o    = err_q ? 4'd0 : rdata_i.dev;
  assign device_offset_o   = err_q ? 48'd0 : rdata_i.doff;
  assign chunk_address_o   = err_q ? 48'd0 : rdata_i.addr;
  assign chunk_bytes_o     = err_q ? 31'd0 : rdata_i.len;
  assign last_o            = err_q | (pend_q & lastp_q);
  assign too_many_chunks_o = err_q;

`ifndef SYNTHESIS
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    too_many_chunks_o |-> (valid_o && last_o)) else $error("error beat without last");
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> !err_q) else $error("error beat repeated");
  a_job_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_i.valid |-> !busy_o) else $error("job handed over while busy");
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> !pend_q) else $error("error beat mixed with data beat");
`endif

endmodule

@@ hw/rtl/stripe_request_splitter_top.sv @@
// ----------------------------------------------------------------------------
// stripe_request_splitter_top
// Splits one striped read or write request into per-device chunk descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write block_pages (0), device_count (1) and row_width (2)
//   through cfg_valid_i/cfg_index_i/cfg_data_i while busy is low; cfg_ready_o
//   is always high.
//   Requests: a request is taken at a clock edge with start high and busy
//   low. busy stays high until the last descriptor of that request is out.
//   Results: each descriptor is on the result ports for one cycle, marked by
//   result_valid_o; last_o flags the final one. A request needing more than
//   MAX_CHUNKS chunks gives a single error beat with too_many_chunks_o set.
//   A zero-byte request gives no beat.
// Sequencing: setup runs two divisions, then each stripe piece runs three
//   divisions on the shared divider and writes its chunks; once the last
//   chunk is written the job is handed to the back end, which then plays
//   out one beat per cycle.
// Throughput: one request at a time.
// Reset: configuration returns to block_pages 1, device_count 1, row_width 0;
//   no request is pending. The receiver cannot stall.
// ----------------------------------------------------------------------------
module stripe_request_splitter_top #(
  parameter int unsigned MAX_DEVICES = 16,
  parameter int unsigned MAX_CHUNKS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [47:0] request_offset_i,
  input  logic [35:0] request_bytes_i,
  input  logic [47:0] mem_address_i,
  output logic        result_valid_o,
  output logic        direction_o,
  output logic [3:0]  device_index_o,
  output logic [47:0] device_offset_o,
  output logic [47:0] chunk_address_o,
  output logic [30:0] chunk_bytes_o,
  output logic        last_o,
  output logic        too_many_chunks_o
);
  import stsp_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned AddrW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  logic [19:0] block_pages_q;
  logic [4:0]  device_count_q;
  logic [47:0] row_width_q;

  logic             front_idle, back_busy, accept;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  stsp_chunk_t      wdata, rdata;
  stsp_job_t        job;
  logic [CntW-1:0]  job_cnt;

  assign cfg_ready_o = 1'b1;
  assign busy        = !front_idle || back_busy;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_pages_q  <= 20'd1;
      device_count_q <= 5'd1;
      row_width_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BLOCK_PAGES:  block_pages_q  <= cfg_data_i[19:0];
        CFG_DEVICE_COUNT: device_count_q <= cfg_data_i[4:0];
        CFG_ROW_WIDTH:    row_width_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  stsp_front #(
    .MaxDevices (MAX_DEVICES),
    .MaxChunks  (MAX_CHUNKS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (accept),
    .func_i           (func_i),
    .request_offset_i (request_offset_i),
    .request_bytes_i  (request_bytes_i),
    .mem_address_i    (mem_address_i),
    .block_pages_i    (block_pages_q),
    .device_count_i   (device_count_q),
    .row_width_i      (row_width_q),
    .idle_o           (front_idle),
    .we_o             (we),
    .waddr_o          (waddr),
    .wdata_o          (wdata),
    .job_o            (job),
    .job_cnt_o        (job_cnt)
  );

  stsp_ram #(
    .Width ($bits(stsp_chunk_t)),
    .Depth (MAX_CHUNKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stsp_back #(
    .MaxChunks (MAX_CHUNKS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_i             (job),
    .job_cnt_i         (job_cnt),
    .raddr_o           (raddr),
    .rdata_i           (rdata),
    .busy_o            (back_busy),
    .valid_o           (result_valid_o),
    .direction_o       (direction_o),
    .device_index_o    (device_index_o),
    .device_offset_o   (device_offset_o),
    .chunk_address_o   (chunk_address_o),
    .chunk_bytes_o     (chunk_bytes_o),
    .last_o            (last_o),
    .too_many_chunks_o (too_many_chunks_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stripe_request_splitter_top: requests are driven in
// random bursts under several stripe configurations, and every descriptor
// beat is compared in order against a chunk predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stsp_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam longint unsigned    PageBytes = 64'd4096;
  localparam int                 ChunkCap  = 64;
  localparam int                 DevCap    = 16;
  localparam int                 IdleLimit = 100000;
  localparam int                 NumPhases = 6;
  localparam int                 PhaseReqs = 84;
  localparam longint unsigned    M48       = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned    M36       = 64'hF_FFFF_FFFF;

  typedef struct {
    logic            dir;
    longint unsigned off;
    longint unsigned nbytes;
    longint unsigned addr;
  } req_t;

  typedef struct {
    logic        dir;
    logic [3:0]  dev;
    logic [47:0] doff;
    logic [47:0] addr;
    logic [30:0] len;
    logic        last;
    logic        err;
  } chunk_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        func_i = 1'b0;
  logic [47:0] request_offset_i = '0;
  logic [35:0] request_bytes_i = '0;
  logic [47:0] mem_address_i = '0;
  logic        result_valid_o;
  logic        direction_o;
  logic [3:0]  device_index_o;
  logic [47:0] device_offset_o;
  logic [47:0] chunk_address_o;
  logic [30:0] chunk_bytes_o;
  logic        last_o;
  logic        too_many_chunks_o;

  stripe_request_splitter_top DUT (.*);

  req_t            pend_reqs[$];
  chunk_t          exp_chunks[$];
  longint unsigned blk_pages, dev_count, row_bytes;
  int              mismatches, n_reqs, n_beats, n_err_beats, idle_cycles;
  int              burst_left, gap_left;
  logic            req_taken = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (beat %0d)", what, got, want, n_beats);
    mismatches++;
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, longint unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[47:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_BLOCK_PAGES:  blk_pages = val & 64'hF_FFFF;
      CFG_DEVICE_COUNT: dev_count = val & 64'h1F;
      CFG_ROW_WIDTH:    row_bytes = val & M48;
      default: ;
    endcase
  endtask

  function automatic req_t gen_req();
    req_t            rq;
    longint unsigned bs, rnd, rnd2;
    int              osel, bsel;
    bs   = ((blk_pages == 0) ? 64'd1 : blk_pages) * PageBytes;
    rnd  = {$urandom, $urandom};
    rnd2 = {$urandom, $urandom};
    osel = $urandom_range(0, 7);
    bsel = $urandom_range(0, 19);
    rq.dir  = 1'($urandom_range(0, 1));
    rq.addr = {$urandom, $urandom} & M48;
    if (osel < 4)
      rq.off = rnd & M48;
    else if (osel < 6)
      rq.off = (longint'($urandom_range(0, 4095)) * bs + rnd % bs) & M48;
    else if (osel == 6)
      rq.off = M48 - (rnd % (3 * bs));
    else
      rq.off = ((longint'($urandom_range(1, 16383)) << RowShift) - (rnd % 8192)) & M48;
    if (bsel == 0)
      rq.nbytes = 0;
    else if (bsel < 10)
      rq.nbytes = $urandom_range(1, 8192);
    else if (bsel < 15)
      rq.nbytes = rnd2 % (4 * bs) + 1;
    else if (bsel < 17)
      rq.nbytes = 64 * bs - rq.off % bs;
    else if (bsel == 17)
      rq.nbytes = 64 * bs - rq.off % bs + 1;
    else
      rq.nbytes = rnd2;
    rq.nbytes &= M36;
    return rq;
  endfunction

  function automatic void split_request(req_t rq);
    chunk_t          cuts[$];
    chunk_t          c;
    longint unsigned bs, nd, k, off, rem, addr, seg, left, t, blk_idx, row, dev, doff;
    bit              overflow;
    bs   = ((blk_pages == 0) ? 64'd1 : blk_pages) * PageBytes;
    nd   = (dev_count == 0) ? 64'd1 : ((dev_count > DevCap) ? DevCap : dev_count);
    k    = (row_bytes / bs) % nd;
    off  = rq.off;
    rem  = rq.nbytes;
    addr = rq.addr;
    overflow = 1'b0;
    while (rem > 0 && !overflow) begin
      blk_idx = (off / bs) % nd;
      row  = off >> RowShift;
      dev  = (blk_idx + row * k) % nd;
      doff = (off / (nd * bs)) * bs + off % bs;
      seg  = bs - off % bs;
      if (seg > rem) seg = rem;
      left = seg;
      while (left > 0 && !overflow) begin
        t = (left < MaxXfer) ? left : MaxXfer;
        if (cuts.size() >= ChunkCap) begin
          overflow = 1'b1;
        end else begin
          c.dir  = rq.dir;
          c.dev  = dev[3:0];
          c.doff = doff[47:0];
          c.addr = addr[47:0];
          c.len  = t[30:0];
          c.last = 1'b0;
          c.err  = 1'b0;
          cuts.push_back(c);
          addr = (addr + t) & M48;
          doff += t;
          left -= t;
        end
      end
      rem -= seg;
      off += seg;
    end
    if (overflow) begin
      c = '{rq.dir, '0, '0, '0, '0, 1'b1, 1'b1};
      exp_chunks.push_back(c);
    end else if (cuts.size() > 0) begin
      cuts[cuts.size()-1].last = 1'b1;
      foreach (cuts[i]) exp_chunks.push_back(cuts[i]);
    end
  endfunction

  // accept requests, check beats
  always @(posedge clk_i) begin
    chunk_t e;
    req_t   rq;
    req_taken <= start && !busy;
    if (rst_ni && start && !busy) begin
      rq = '{func_i, request_offset_i, request_bytes_i, mem_address_i};
      split_request(rq);
      n_reqs++;
    end
    if (rst_ni && result_valid_o) begin
      n_beats++;
      if (too_many_chunks_o) n_err_beats++;
      if (exp_chunks.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        e = exp_chunks.pop_front();
        if (direction_o !== e.dir) report("direction", direction_o, e.dir);
        if (device_index_o !== e.dev) report("device_index", device_index_o, e.dev);
        if (device_offset_o !== e.doff) report("device_offset", device_offset_o, e.doff);
        if (chunk_address_o !== e.addr) report("chunk_address", chunk_address_o, e.addr);
        if (chunk_bytes_o !== e.len) report("chunk_bytes", chunk_bytes_o, e.len);
        if (last_o !== e.last) report("last", last_o, e.last);
        if (too_many_chunks_o !== e.err) report("too_many_chunks", too_many_chunks_o, e.err);
      end
    end
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no activity for %0d cycles", IdleLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    logic nxt_start;
    nxt_start = start;
    if (req_taken) begin
      void'(pend_reqs.pop_front());
      nxt_start = 1'b0;
    end
    if (rst_ni && !nxt_start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_reqs.size() > 0) begin
        func_i           <= pend_reqs[0].dir;
        request_offset_i <= pend_reqs[0].off[47:0];
        request_bytes_i  <= pend_reqs[0].nbytes[35:0];
        mem_address_i    <= pend_reqs[0].addr[47:0];
        nxt_start = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    start <= nxt_start;
  end

  // reset, configure, fill the queue phase by phase, drain between phases
  initial begin
    blk_pages = 1;
    dev_count = 1;
    row_bytes = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: begin
          cfg_write(CFG_DEVICE_COUNT, 64'd4);
          cfg_write(CFG_ROW_WIDTH, {$urandom, $urandom});
        end
        2: begin
          cfg_write(CFG_BLOCK_PAGES, 64'd0);
          cfg_write(CFG_DEVICE_COUNT, 64'd0);
          cfg_write(CFG_ROW_WIDTH, 64'd12288);
        end
        3: begin
          cfg_write(CFG_BLOCK_PAGES, 64'd3);
          cfg_write(CFG_DEVICE_COUNT, 64'd20);
          cfg_write(CFG_ROW_WIDTH, 64'h0123_4567_89AB);
        end
        4: begin
          cfg_write(CFG_BLOCK_PAGES, 64'd524288);
          cfg_write(CFG_DEVICE_COUNT, 64'd7);
          cfg_write(CfgUnused, M48);
          cfg_write(CFG_ROW_WIDTH, {$urandom, $urandom});
        end
        5: begin
          cfg_write(CFG_BLOCK_PAGES, 64'd1000);
          cfg_write(CFG_DEVICE_COUNT, 64'd31);
          cfg_write(CFG_ROW_WIDTH, {$urandom, $urandom});
        end
        default: ;
      endcase
      repeat (PhaseReqs) pend_reqs.push_back(gen_req());
      wait (pend_reqs.size() == 0 && exp_chunks.size() == 0 && !busy && !start);
      repeat (2) @(negedge clk_i);
    end
    if (exp_chunks.size() != 0) report("missing beats", exp_chunks.size(), 0);
    $display("Ran %0d requests over %0d stripe setups: empty, block-edge, row-crossing,",
             n_reqs, NumPhases);
    $display("top-of-range and chunk-limit cases; %0d beats checked, %0d error beats.",
             n_beats, n_err_beats);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/stsp_pkg.sv
hw/rtl/stsp_ram.sv
hw/rtl/stsp_div.sv
hw/rtl/stsp_front.sv
hw/rtl/stsp_back.sv
hw/rtl/stripe_request_splitter_top.sv
tb/sv/tb_top.sv
